// ----- hdl/psm_pkg.sv -----
// shared constants, sequencer state type and mask port request for the polygon mask block
// no dependencies
package psm_pkg;

    localparam int MAX_VERTS = 64;
    localparam int MAX_SPAN  = 256;
    localparam int FRAC_BITS = 16;

    localparam int COORD_W = 10;                       // image coordinate
    localparam int REL_W   = $clog2(MAX_SPAN);         // offset inside the box
    localparam int SIZE_W  = 11;                       // box width / height
    localparam int VIDX_W  = $clog2(MAX_VERTS);        // vertex / edge / crossing index
    localparam int VCNT_W  = VIDX_W + 1;               // count up to MAX_VERTS + 1
    localparam int POS_W   = REL_W + 2;                // signed column cursor
    localparam int DIV_W   = REL_W + FRAC_BITS;        // dividend and quotient
    localparam int SLOPE_W = DIV_W + 1;
    localparam int PROD_W  = SLOPE_W + REL_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MADDR_W = 2 * REL_W;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SPAN     = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

    localparam logic [1:0] CLASS_OUTSIDE  = 2'd0;
    localparam logic [1:0] CLASS_INSIDE   = 2'd1;
    localparam logic [1:0] CLASS_BOUNDARY = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_BOX_RD,
        ST_BOX_ACC,
        ST_BOX_CHK,
        ST_CLEAR,
        ST_EDGE_RD,
        ST_EDGE,
        ST_DIV,
        ST_HLINE,
        ST_NEXT_V,
        ST_ROW,
        ST_E_RD,
        ST_E_CHK,
        ST_E_X0,
        ST_E_X1,
        ST_RUN,
        ST_INS_RD,
        ST_INS_CMP,
        ST_NEXT_E,
        ST_PAIR,
        ST_PA,
        ST_PB,
        ST_PZ,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_REPORT
    } psm_state_t;

    typedef struct packed {
        logic                    wr;
        logic                    rd;
        logic signed [POS_W-1:0] col;
        logic [REL_W-1:0]        row;
        logic [1:0]              data;
    } psm_mask_req_t;

endpackage

// ----- hdl/polygon_scanline_mask.sv -----
// top level of the polygon scanline mask: sequencer, vertex, edge and crossing memories
// depends on psm_pkg, psm_divider, psm_mask
//
// vertices stream in one item per cycle while the input is ready (command 0); the item
// with tlast set closes the polygon and starts a fill, during which s_axis_tready stays
// low. the fill runs as a small sequencer around one multiplier, one divider and
// single-port mask accesses: a read and an accumulate step per vertex for the bounding
// box, one write per pixel to clear the used part of the mask, a wait on the bit-serial
// divider for each sloped edge, one write per pixel of each horizontal edge, then per
// interior row a check of each edge, for each active edge its two crossing columns, a
// write per boundary pixel of its crossing run and an insertion shift, and per crossing
// pair its two end pixels and a read and a conditional write per pixel between them. a
// fill ends with a report item (tuser 0). a read item (command 1) returns the class of
// one pixel, read from the mask in the read state after the item and then registered;
// the input is not ready in that state. the answer carries the status and box size of
// the last fill; pixels outside the box, or any pixel when the last fill did not succeed,
// read as outside. more than 64 vertices give status 2 and no mask; a box over 256
// pixels on either side gives status 1. loads are taken every cycle while idle; a new
// item is taken while a result leaves the output register in the same cycle.
module polygon_scanline_mask
    import psm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // vertex_x[9:0], vertex_y[19:10], read_col[27:20],
                                       // read_row[35:28], zeros
    input  logic        s_axis_tlast,  // last_vertex
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // status[1:0], box_width[12:2], box_height[23:13],
                                       // mask_class[25:24], zeros
    output logic        m_axis_tuser   // result_kind
);

    // input fields
    logic [COORD_W-1:0] in_x, in_y;
    logic [REL_W-1:0]   in_rc, in_rr;
    logic               accept;

    assign in_x   = s_axis_tdata[9:0];
    assign in_y   = s_axis_tdata[19:10];
    assign in_rc  = s_axis_tdata[27:20];
    assign in_rr  = s_axis_tdata[35:28];
    assign accept = s_axis_tvalid && s_axis_tready;

    psm_state_t state_reg, state_next;

    // sequencer counters and results
    logic [VCNT_W-1:0] cnt_reg, cnt_next;
    logic [VCNT_W-1:0] idx_reg, idx_next;
    logic [VCNT_W-1:0] ne_reg, ne_next;
    logic [VCNT_W-1:0] e_reg, e_next;
    logic [VCNT_W-1:0] nc_reg, nc_next;
    logic [VCNT_W-1:0] k_reg, k_next;
    logic [REL_W-1:0]  row_reg, row_next;
    logic [REL_W-1:0]  ccol_reg, ccol_next;
    logic [REL_W-1:0]  crow_reg, crow_next;
    logic [COORD_W-1:0] left_reg, left_next, right_reg, right_next;
    logic [COORD_W-1:0] bot_reg, bot_next, top_reg, top_next;
    logic [SIZE_W-1:0] w_reg, w_next, h_reg, h_next;
    logic [1:0]        status_reg, status_next;
    logic              mvalid_reg, mvalid_next;
    logic              ovalid_reg, ovalid_next;
    logic              okind_reg, okind_next;
    logic [1:0]        oclass_reg, oclass_next;

    // datapath registers
    logic signed [POS_W-1:0]  x_reg, x_next;       // run / fill cursor
    logic signed [POS_W-1:0]  xe_reg, xe_next;     // run end or pair end
    logic signed [POS_W-1:0]  xc_reg, xc_next;     // crossing being inserted
    logic                     neg_reg, neg_next;   // step direction / slope sign
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [REL_W-1:0]         ex0_reg, ex0_next, ey0_reg, ey0_next, ey1_reg, ey1_next;

    // vertex memories, two read ports
    logic [COORD_W-1:0] vcol_mem [0:MAX_VERTS-1];
    logic [COORD_W-1:0] vrow_mem [0:MAX_VERTS-1];
    logic [VIDX_W-1:0]  va_addr, vb_addr;
    logic [COORD_W-1:0] vxa_q, vya_q, vxb_q, vyb_q;
    logic               v_we;

    // edge table memory
    logic [REL_W-1:0]          et_x0_mem [0:MAX_VERTS-1];
    logic signed [SLOPE_W-1:0] et_s_mem  [0:MAX_VERTS-1];
    logic [REL_W-1:0]          et_lo_mem [0:MAX_VERTS-1];
    logic [REL_W-1:0]          et_hi_mem [0:MAX_VERTS-1];
    logic [REL_W-1:0]          eq_x0, eq_lo, eq_hi;
    logic signed [SLOPE_W-1:0] eq_s;
    logic                      et_we;
    logic signed [SLOPE_W-1:0] et_wslope;

    // crossing list memory
    logic signed [POS_W-1:0] cl_mem [0:MAX_VERTS-1];
    logic signed [POS_W-1:0] cl_q, cl_wdata;
    logic [VIDX_W-1:0]       cl_raddr, cl_waddr;
    logic                    cl_we;

    // shared units
    psm_mask_req_t     mreq;
    logic [1:0]        rd_class;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, quotient;
    logic [REL_W-1:0]  div_divisor;
    logic [REL_W-1:0]  mul_b;
    logic signed [SUM_W-1:0] fsum;
    logic signed [POS_W-1:0] fx;

    // positions relative to the box
    logic [REL_W-1:0] xa, ya, xb, yb;
    logic [COORD_W-1:0] da_x, da_y, db_x, db_y;
    logic [REL_W-1:0] sx0, sy0, sx1, sy1;
    logic signed [REL_W:0] dx;
    logic [REL_W-1:0] adx;
    logic [SIZE_W-1:0] box_w, box_h;

    assign da_x = vxa_q - left_reg;
    assign da_y = vya_q - bot_reg;
    assign db_x = vxb_q - left_reg;
    assign db_y = vyb_q - bot_reg;
    assign xa = da_x[REL_W-1:0];
    assign ya = da_y[REL_W-1:0];
    assign xb = db_x[REL_W-1:0];
    assign yb = db_y[REL_W-1:0];
    assign sx0 = (ya < yb) ? xa : xb;
    assign sy0 = (ya < yb) ? ya : yb;
    assign sx1 = (ya < yb) ? xb : xa;
    assign sy1 = (ya < yb) ? yb : ya;
    assign dx  = $signed({1'b0, sx1}) - $signed({1'b0, sx0});
    assign adx = dx[REL_W] ? REL_W'(-dx) : dx[REL_W-1:0];
    assign box_w = SIZE_W'({1'b0, right_reg} - {1'b0, left_reg} + 1'b1);
    assign box_h = SIZE_W'({1'b0, top_reg} - {1'b0, bot_reg} + 1'b1);

    assign div_dividend = {adx, {FRAC_BITS{1'b0}}};
    assign div_divisor  = sy1 - sy0;
    assign et_wslope    = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

    // floor of the fixed point crossing column
    assign fsum = $signed({{(SUM_W-DIV_W){1'b0}}, eq_x0, {FRAC_BITS{1'b0}}})
                  + SUM_W'(prod_reg);
    assign fx   = fsum[FRAC_BITS +: POS_W];

    psm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    psm_mask u_mask (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mreq),
        .box_w    (w_reg),
        .box_h    (h_reg),
        .rd_class (rd_class)
    );

    // memories
    assign v_we = accept && (s_axis_tuser == CMD_LOAD) && (cnt_reg < VCNT_W'(MAX_VERTS));

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vcol_mem[cnt_reg[VIDX_W-1:0]] <= in_x;
            vrow_mem[cnt_reg[VIDX_W-1:0]] <= in_y;
        end
        vxa_q <= vcol_mem[va_addr];
        vya_q <= vrow_mem[va_addr];
        vxb_q <= vcol_mem[vb_addr];
        vyb_q <= vrow_mem[vb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (et_we)
        begin
            et_x0_mem[ne_reg[VIDX_W-1:0]] <= ex0_reg;
            et_s_mem[ne_reg[VIDX_W-1:0]]  <= et_wslope;
            et_lo_mem[ne_reg[VIDX_W-1:0]] <= ey0_reg;
            et_hi_mem[ne_reg[VIDX_W-1:0]] <= ey1_reg;
        end
        eq_x0 <= et_x0_mem[e_reg[VIDX_W-1:0]];
        eq_s  <= et_s_mem[e_reg[VIDX_W-1:0]];
        eq_lo <= et_lo_mem[e_reg[VIDX_W-1:0]];
        eq_hi <= et_hi_mem[e_reg[VIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cl_we)
        begin
            cl_mem[cl_waddr] <= cl_wdata;
        end
        cl_q <= cl_mem[cl_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == CMD_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = (cnt_reg >= VCNT_W'(MAX_VERTS)) ? ST_REPORT : ST_BOX_RD;
                    end
                end
            end
            ST_READ:    state_next = ST_IDLE;
            ST_BOX_RD:  state_next = ST_BOX_ACC;
            ST_BOX_ACC: state_next = (idx_reg + 1'b1 == cnt_reg) ? ST_BOX_CHK : ST_BOX_RD;
            ST_BOX_CHK:
            begin
                if (box_w > SIZE_W'(MAX_SPAN) || box_h > SIZE_W'(MAX_SPAN))
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if ({3'b0, ccol_reg} + 1'b1 == w_reg && {3'b0, crow_reg} + 1'b1 == h_reg)
                begin
                    state_next = ST_EDGE_RD;
                end
            end
            ST_EDGE_RD: state_next = ST_EDGE;
            ST_EDGE:    state_next = (ya != yb) ? ST_DIV : ST_HLINE;
            ST_DIV:     state_next = div_done ? ST_NEXT_V : ST_DIV;
            ST_HLINE:   state_next = (x_reg == $signed({2'b0, xb})) ? ST_NEXT_V : ST_HLINE;
            ST_NEXT_V:  state_next = (idx_reg + 1'b1 == cnt_reg) ? ST_ROW : ST_EDGE_RD;
            ST_ROW:
            begin
                if ({3'b0, row_reg} + 1'b1 < h_reg)
                begin
                    state_next = (ne_reg == '0) ? ST_PAIR : ST_E_RD;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_E_RD:    state_next = ST_E_CHK;
            ST_E_CHK:   state_next = (eq_lo > row_reg || eq_hi <= row_reg) ? ST_NEXT_E : ST_E_X0;
            ST_E_X0:    state_next = ST_E_X1;
            ST_E_X1:    state_next = ST_RUN;
            ST_RUN:     state_next = (x_reg == xe_reg) ? ST_INS_RD : ST_RUN;
            ST_INS_RD:  state_next = (k_reg == '0) ? ST_NEXT_E : ST_INS_CMP;
            ST_INS_CMP: state_next = (cl_q > xc_reg) ? ST_INS_RD : ST_NEXT_E;
            ST_NEXT_E:  state_next = (e_reg + 1'b1 == ne_reg) ? ST_PAIR : ST_E_RD;
            ST_PAIR:    state_next = (k_reg + 1'b1 < nc_reg) ? ST_PA : ST_ROW;
            ST_PA:      state_next = ST_PB;
            ST_PB:      state_next = ST_PZ;
            ST_PZ:      state_next = ST_FILL_RD;
            ST_FILL_RD: state_next = (x_reg < xe_reg) ? ST_FILL_WR : ST_PAIR;
            ST_FILL_WR: state_next = ST_FILL_RD;
            ST_REPORT:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        ne_next     = ne_reg;
        e_next      = e_reg;
        nc_next     = nc_reg;
        k_next      = k_reg;
        row_next    = row_reg;
        ccol_next   = ccol_reg;
        crow_next   = crow_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        bot_next    = bot_reg;
        top_next    = top_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        status_next = status_reg;
        mvalid_next = mvalid_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        okind_next  = okind_reg;
        oclass_next = oclass_reg;
        x_next      = x_reg;
        xe_next     = xe_reg;
        xc_next     = xc_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        ex0_next    = ex0_reg;
        ey0_next    = ey0_reg;
        ey1_next    = ey1_reg;

        s_axis_tready = (state_reg == ST_IDLE) && (!ovalid_reg || m_axis_tready);
        va_addr   = idx_reg[VIDX_W-1:0];
        vb_addr   = (idx_reg + 1'b1 < cnt_reg) ? VIDX_W'(idx_reg + 1'b1) : '0;
        et_we     = 1'b0;
        cl_we     = 1'b0;
        cl_waddr  = k_reg[VIDX_W-1:0];
        cl_wdata  = xc_reg;
        cl_raddr  = VIDX_W'(k_reg - 1'b1);
        div_start = 1'b0;
        mul_b     = row_reg - eq_lo;
        mreq      = '{wr: 1'b0, rd: 1'b0, col: x_reg, row: row_reg, data: CLASS_BOUNDARY};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == CMD_READ)
                    begin
                        mreq.rd  = 1'b1;
                        mreq.col = $signed({2'b0, in_rc});
                        mreq.row = in_rr;
                    end
                    else
                    begin
                        cnt_next = (cnt_reg < VCNT_W'(MAX_VERTS)) ? cnt_reg + 1'b1
                                                                 : VCNT_W'(MAX_VERTS + 1);
                        if (s_axis_tlast)
                        begin
                            mvalid_next = 1'b0;
                            idx_next    = '0;
                            if (cnt_reg >= VCNT_W'(MAX_VERTS))
                            begin
                                status_next = STATUS_TOO_MANY;
                                w_next      = '0;
                                h_next      = '0;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                ovalid_next = 1'b1;
                okind_next  = KIND_READ;
                oclass_next = mvalid_reg ? rd_class : CLASS_OUTSIDE;
            end
            ST_BOX_ACC:
            begin
                if (idx_reg == '0)
                begin
                    left_next  = vxa_q;
                    right_next = vxa_q;
                    bot_next   = vya_q;
                    top_next   = vya_q;
                end
                else
                begin
                    if (vxa_q < left_reg)  left_next  = vxa_q;
                    if (vxa_q > right_reg) right_next = vxa_q;
                    if (vya_q < bot_reg)   bot_next   = vya_q;
                    if (vya_q > top_reg)   top_next   = vya_q;
                end
                idx_next = (idx_reg + 1'b1 == cnt_reg) ? '0 : idx_reg + 1'b1;
            end
            ST_BOX_CHK:
            begin
                w_next    = box_w;
                h_next    = box_h;
                ccol_next = '0;
                crow_next = '0;
                ne_next   = '0;
                if (box_w > SIZE_W'(MAX_SPAN) || box_h > SIZE_W'(MAX_SPAN))
                begin
                    status_next = STATUS_SPAN;
                end
                else
                begin
                    status_next = STATUS_OK;
                    mvalid_next = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                mreq.wr   = 1'b1;
                mreq.col  = $signed({2'b0, ccol_reg});
                mreq.row  = crow_reg;
                mreq.data = CLASS_OUTSIDE;
                if ({3'b0, ccol_reg} + 1'b1 == w_reg)
                begin
                    ccol_next = '0;
                    crow_next = crow_reg + 1'b1;
                end
                else
                begin
                    ccol_next = ccol_reg + 1'b1;
                end
            end
            ST_EDGE:
            begin
                // vertex itself is boundary
                mreq.wr  = 1'b1;
                mreq.col = $signed({2'b0, xa});
                mreq.row = ya;
                if (ya != yb)
                begin
                    div_start = 1'b1;
                    neg_next  = dx[REL_W];
                    ex0_next  = sx0;
                    ey0_next  = sy0;
                    ey1_next  = sy1;
                end
                else
                begin
                    x_next   = $signed({2'b0, xa});
                    neg_next = !(xa < xb);
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    et_we   = 1'b1;
                    ne_next = ne_reg + 1'b1;
                end
            end
            ST_HLINE:
            begin
                mreq.row = ya;
                if (x_reg != $signed({2'b0, xb}))
                begin
                    mreq.wr = 1'b1;
                    x_next  = neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                end
            end
            ST_NEXT_V:
            begin
                idx_next = idx_reg + 1'b1;
                row_next = REL_W'(1);
            end
            ST_ROW:
            begin
                nc_next = '0;
                e_next  = '0;
                k_next  = '0;
            end
            ST_E_CHK:
            begin
                mul_b     = row_reg - eq_lo;
                prod_next = eq_s * $signed({1'b0, mul_b});
            end
            ST_E_X0:
            begin
                x_next    = fx;
                xc_next   = fx;
                mul_b     = row_reg + 1'b1 - eq_lo;
                prod_next = eq_s * $signed({1'b0, mul_b});
            end
            ST_E_X1:
            begin
                xe_next  = fx;
                neg_next = !(eq_s > 0);
                k_next   = nc_reg;
            end
            ST_RUN:
            begin
                if (x_reg != xe_reg)
                begin
                    mreq.wr = 1'b1;
                    x_next  = neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                end
            end
            ST_INS_RD:
            begin
                if (k_reg == '0)
                begin
                    cl_we   = 1'b1;
                    nc_next = nc_reg + 1'b1;
                end
            end
            ST_INS_CMP:
            begin
                cl_we = 1'b1;
                if (cl_q > xc_reg)
                begin
                    cl_wdata = cl_q;
                    k_next   = k_reg - 1'b1;
                end
                else
                begin
                    nc_next = nc_reg + 1'b1;
                end
            end
            ST_NEXT_E:
            begin
                e_next = e_reg + 1'b1;
                k_next = '0;
            end
            ST_PAIR:
            begin
                cl_raddr = k_reg[VIDX_W-1:0];
                if (!(k_reg + 1'b1 < nc_reg))
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_PA:
            begin
                cl_raddr = VIDX_W'(k_reg + 1'b1);
                x_next   = cl_q;
            end
            ST_PB:
            begin
                xe_next = cl_q;
                mreq.wr = 1'b1;
            end
            ST_PZ:
            begin
                mreq.wr  = 1'b1;
                mreq.col = xe_reg;
                x_next   = x_reg + 1'b1;
            end
            ST_FILL_RD:
            begin
                if (x_reg < xe_reg)
                begin
                    mreq.rd = 1'b1;
                end
                else
                begin
                    k_next = k_reg + 2'd2;
                end
            end
            ST_FILL_WR:
            begin
                if (rd_class == CLASS_OUTSIDE)
                begin
                    mreq.wr   = 1'b1;
                    mreq.data = CLASS_INSIDE;
                end
                x_next = x_reg + 1'b1;
            end
            ST_REPORT:
            begin
                ovalid_next = 1'b1;
                okind_next  = KIND_REPORT;
                oclass_next = CLASS_OUTSIDE;
                cnt_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            ne_reg     <= '0;
            e_reg      <= '0;
            nc_reg     <= '0;
            k_reg      <= '0;
            row_reg    <= '0;
            ccol_reg   <= '0;
            crow_reg   <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            bot_reg    <= '0;
            top_reg    <= '0;
            w_reg      <= '0;
            h_reg      <= '0;
            status_reg <= STATUS_OK;
            mvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            okind_reg  <= KIND_REPORT;
            oclass_reg <= CLASS_OUTSIDE;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            ne_reg     <= ne_next;
            e_reg      <= e_next;
            nc_reg     <= nc_next;
            k_reg      <= k_next;
            row_reg    <= row_next;
            ccol_reg   <= ccol_next;
            crow_reg   <= crow_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            bot_reg    <= bot_next;
            top_reg    <= top_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            status_reg <= status_next;
            mvalid_reg <= mvalid_next;
            ovalid_reg <= ovalid_next;
            okind_reg  <= okind_next;
            oclass_reg <= oclass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        xe_reg   <= xe_next;
        xc_reg   <= xc_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        ex0_reg  <= ex0_next;
        ey0_reg  <= ey0_next;
        ey1_reg  <= ey1_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tdata  = {6'b0, oclass_reg, h_reg, w_reg, status_reg};

endmodule

// ----- hdl/psm_divider.sv -----
// iterative restoring divider, one quotient bit per cycle, for the edge slopes
// depends on psm_pkg
module psm_divider
    import psm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [REL_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REL_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [REL_W-1:0] dvs_reg, dvs_next;
    logic [REL_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, q_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = REL_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[REL_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- hdl/psm_mask.sv -----
// class mask memory, one pixel per access, with box clipping on reads and writes
// depends on psm_pkg
module psm_mask
    import psm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  psm_mask_req_t     req,
    input  logic [SIZE_W-1:0] box_w,
    input  logic [SIZE_W-1:0] box_h,
    output logic [1:0]        rd_class
);

    logic [1:0]         mem [0:(1 << MADDR_W) - 1];
    logic [1:0]         q_reg;
    logic               hit_reg;
    logic               in_box;
    logic [MADDR_W-1:0] addr;

    // pixels outside the box are never stored and read as outside
    assign in_box = !req.col[POS_W-1]
                    && ({1'b0, req.col} < $signed({1'b0, box_w}))
                    && ({3'b0, req.row} < box_h);
    assign addr   = {req.row, req.col[REL_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (req.wr && in_box)
        begin
            mem[addr] <= req.data;
        end
        q_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= req.rd && in_box;
        end
    end

    assign rd_class = hit_reg ? q_reg : CLASS_OUTSIDE;

endmodule

// ----- tb/psm_checker.sv -----
// checker for polygon_scanline_mask: watches both streams, predicts every answer
// and compares it field by field; depends on psm_pkg
module psm_checker
    import psm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [10:0] width;
        logic [10:0] height;
        logic [1:0]  cls;
    } answer_t;

    answer_t answers_due[$];

    int         vcol [MAX_VERTS];
    int         vrow [MAX_VERTS];
    int         vcount;
    logic [1:0] mask_img [MAX_SPAN*MAX_SPAN];
    logic [1:0] fill_status;
    int         fill_w;
    int         fill_h;
    bit         mask_ok;

    longint     e_start [MAX_VERTS];
    longint     e_slope [MAX_VERTS];
    longint     e_lo    [MAX_VERTS];
    longint     e_hi    [MAX_VERTS];
    longint     xings   [MAX_VERTS+1];

    function automatic void paint(longint c, longint r, logic [1:0] v);
        if (c < 0 || r < 0 || c >= fill_w || r >= fill_h)
            return;
        mask_img[r*MAX_SPAN + c] = v;
    endfunction

    function automatic logic [1:0] pixel_at(longint c, longint r);
        if (c < 0 || r < 0 || c >= fill_w || r >= fill_h)
            return CLASS_OUTSIDE;
        return mask_img[r*MAX_SPAN + c];
    endfunction

    // floor of a fixed-point column
    function automatic longint col_floor(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic void scan_fill();
        int     n, nedge, nx, nc, k;
        longint l, r, b, t, xa, ya, xb, yb, x0, y0, x1, y1, x, xe, stp, a, z;
        foreach (mask_img[i]) mask_img[i] = CLASS_OUTSIDE;
        mask_ok = 0;
        if (vcount > MAX_VERTS)
        begin
            fill_status = STATUS_TOO_MANY;
            fill_w = 0;
            fill_h = 0;
            return;
        end
        n = vcount;
        l = vcol[0]; r = vcol[0]; b = vrow[0]; t = vrow[0];
        for (int i = 1; i < n; i++)
        begin
            if (vcol[i] < l) l = vcol[i];
            if (vcol[i] > r) r = vcol[i];
            if (vrow[i] < b) b = vrow[i];
            if (vrow[i] > t) t = vrow[i];
        end
        fill_w = r - l + 1;
        fill_h = t - b + 1;
        if (fill_w > MAX_SPAN || fill_h > MAX_SPAN)
        begin
            fill_status = STATUS_SPAN;
            return;
        end
        fill_status = STATUS_OK;
        mask_ok = 1;
        nedge = 0;
        // vertices and horizontal edges, edge table of the sloped ones
        for (int i = 0; i < n; i++)
        begin
            nx = (i + 1 < n) ? i + 1 : 0;
            xa = vcol[i] - l;  ya = vrow[i] - b;
            xb = vcol[nx] - l; yb = vrow[nx] - b;
            paint(xa, ya, CLASS_BOUNDARY);
            if (ya != yb)
            begin
                x0 = (ya < yb) ? xa : xb; y0 = (ya < yb) ? ya : yb;
                x1 = (ya < yb) ? xb : xa; y1 = (ya < yb) ? yb : ya;
                e_start[nedge] = x0 <<< FRAC_BITS;
                e_slope[nedge] = ((x1 - x0) <<< FRAC_BITS) / (y1 - y0);
                e_lo[nedge] = y0;
                e_hi[nedge] = y1;
                nedge++;
            end
            else
            begin
                stp = (xa < xb) ? 1 : -1;
                for (x = xa; x != xb; x += stp)
                    paint(x, ya, CLASS_BOUNDARY);
            end
        end
        // interior rows: crossing runs, sorted crossings, fill between pairs
        for (longint row = 1; row < t - b; row++)
        begin
            nc = 0;
            for (int e = 0; e < nedge; e++)
            begin
                if (e_lo[e] > row || e_hi[e] <= row)
                    continue;
                x  = col_floor(e_start[e] + e_slope[e] * (row - e_lo[e]));
                xe = col_floor(e_start[e] + e_slope[e] * (row + 1 - e_lo[e]));
                stp = (e_slope[e] > 0) ? 1 : -1;
                while (x != xe)
                begin
                    paint(x, row, CLASS_BOUNDARY);
                    x += stp;
                end
                x = col_floor(e_start[e] + e_slope[e] * (row - e_lo[e]));
                k = nc;
                while (k > 0 && xings[k-1] > x)
                begin
                    xings[k] = xings[k-1];
                    k--;
                end
                xings[k] = x;
                nc++;
            end
            for (k = 0; k + 1 < nc; k += 2)
            begin
                a = xings[k];
                z = xings[k+1];
                paint(a, row, CLASS_BOUNDARY);
                paint(z, row, CLASS_BOUNDARY);
                for (x = a + 1; x < z; x++)
                    if (pixel_at(x, row) == CLASS_OUTSIDE)
                        paint(x, row, CLASS_INSIDE);
            end
        end
    endfunction

    // one accepted item, maybe one answer
    function automatic void take_item(logic cmd, logic [39:0] d, logic last);
        answer_t ans;
        int      rc, rr;
        rc = d[27:20];
        rr = d[35:28];
        if (cmd == CMD_READ)
        begin
            ans.kind = KIND_READ;
            ans.cls  = (mask_ok && rc < fill_w && rr < fill_h) ?
                       mask_img[rr*MAX_SPAN + rc] : CLASS_OUTSIDE;
        end
        else
        begin
            if (vcount < MAX_VERTS)
            begin
                vcol[vcount] = d[9:0];
                vrow[vcount] = d[19:10];
                vcount++;
            end
            else
                vcount = MAX_VERTS + 1;
            if (!last)
                return;
            scan_fill();
            vcount = 0;
            ans.kind = KIND_REPORT;
            ans.cls  = CLASS_OUTSIDE;
        end
        ans.status = fill_status;
        ans.width  = fill_w[10:0];
        ans.height = fill_h[10:0];
        answers_due.insert(answers_due.size(), ans);
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        vcount = 0;
        fill_status = STATUS_OK;
        fill_w = 0;
        fill_h = 0;
        mask_ok = 0;
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result item with nothing expected");
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    compare_field("result_kind", want.kind, m_axis_tuser);
                    compare_field("status", want.status, m_axis_tdata[1:0]);
                    compare_field("box_width", want.width, m_axis_tdata[12:2]);
                    compare_field("box_height", want.height, m_axis_tdata[23:13]);
                    compare_field("mask_class", want.cls, m_axis_tdata[25:24]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        end
        pending = answers_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// top of the polygon_scanline_mask testbench: clock, reset, stimulus and verdict
// depends on psm_pkg, psm_checker and the block itself
module tb_top
    import psm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          errors;
    int          pending;

    bit          calm;       // no idling on either side near the end
    int          stall_left;
    int          items_sent;

    polygon_scanline_mask u_dut (.*);

    psm_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // global limit: the slowest run is the full 256x256 fill
    initial
    begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: ready drops in bursts of random length
    always @(posedge clk)
    begin
        if (calm || !rst_n)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // one item on the input stream, with an optional gap before it
    task automatic send_item(logic cmd, int x, int y, logic last, int rc, int rr);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {4'd0, rr[7:0], rc[7:0], y[9:0], x[9:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_vertex(int x, int y, logic last);
        send_item(CMD_LOAD, x, y, last, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic read_pixel(int c, int r);
        send_item(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1), c, r);
    endtask

    // random polygon of n vertices inside a w by h box, then some reads of it
    task automatic random_polygon(int n, int w, int h, int nreads);
        int x0, y0;
        x0 = $urandom_range(0, 1024 - w);
        y0 = $urandom_range(0, 1024 - h);
        for (int i = 0; i < n; i++)
            load_vertex(x0 + $urandom_range(0, w - 1), y0 + $urandom_range(0, h - 1),
                        i == n - 1);
        for (int i = 0; i < nreads; i++)
            if ($urandom_range(0, 5) == 0)
                read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
            else
                read_pixel($urandom_range(0, (w < 250) ? w + 2 : 255),
                           $urandom_range(0, (h < 250) ? h + 2 : 255));
    endtask

    initial
    begin
        int pick, w, h;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = CMD_LOAD;
        m_axis_tready = 1'b1;
        calm          = 0;
        stall_left    = 0;
        items_sent    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read before any fill: answers with all-zero data
        read_pixel(0, 0);
        read_pixel(255, 255);
        // triangle with a horizontal bottom edge
        load_vertex(10, 20, 0);
        load_vertex(30, 20, 0);
        load_vertex(20, 40, 1);
        read_pixel(10, 10);
        read_pixel(0, 0);
        read_pixel(25, 25);
        // single vertex and a two-vertex degenerate polygon
        load_vertex(1023, 1023, 1);
        read_pixel(0, 0);
        load_vertex(0, 0, 0);
        load_vertex(5, 9, 1);
        read_pixel(2, 4);
        // largest box that still fills, a concave outline with two crossings on every interior row
        load_vertex(0, 0, 0);
        load_vertex(255, 0, 0);
        load_vertex(128, 128, 0);
        load_vertex(255, 255, 0);
        load_vertex(0, 255, 1);
        read_pixel(255, 255);
        read_pixel(128, 200);
        read_pixel(128, 10);
        // box one past the span limit, and a full-image box
        load_vertex(0, 0, 0);
        load_vertex(256, 3, 1);
        load_vertex(0, 0, 0);
        load_vertex(1023, 1023, 1);
        read_pixel(0, 0);

        // random part: mostly well-formed polygons followed by reads
        while (items_sent < 500)
        begin
            pick = $urandom_range(0, 99);
            if (items_sent > 430)
                calm = 1;
            if (pick < 70)
            begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 40);
                random_polygon($urandom_range(3, 10), w, h, $urandom_range(1, 6));
            end
            else if (pick < 75)
                random_polygon($urandom_range(3, 12), $urandom_range(200, 256),
                               $urandom_range(1, 24), 3);
            else if (pick < 80)
                random_polygon(64, $urandom_range(2, 30), $urandom_range(2, 30), 2);
            else if (pick < 85)
                random_polygon($urandom_range(65, 70), 20, 20, 1);
            else if (pick < 92)
                random_polygon($urandom_range(2, 6), $urandom_range(257, 1024),
                               $urandom_range(1, 1024), 1);
            else
                read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
        end
        s_axis_tvalid <= 1'b0;

        // let the checker register the last item before watching its queue
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/psm_pkg.sv
hdl/psm_divider.sv
hdl/psm_mask.sv
hdl/polygon_scanline_mask.sv
tb/psm_checker.sv
tb/tb_top.sv
